// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the flow hash core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/fth_pkg.sv =====
// ----------------------------------------------------------------------------
// fth_pkg
// Types, constants and mixing functions for the flow tuple hash.
// ----------------------------------------------------------------------------
package fth_pkg;

    localparam logic [31:0] SEED_BASE = 32'hdeadbeef;
    localparam logic [31:0] SEED_LEN  = 32'd3 << 2;
    localparam logic [31:0] SEED_INIT = SEED_BASE + SEED_LEN;

    typedef logic [31:0] word_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
    } abc_t;

    function automatic word_t rotl(input word_t x, input logic [4:0] k);
        word_t r;
        r = (x << k) | (x >> (6'd32 - {1'b0, k}));
        return r;
    endfunction

    // mix round step: x = (x - y) ^ rotl(y, k)
    function automatic word_t mix_word(input word_t x, input word_t y, input logic [4:0] k);
        word_t r;
        r = (x - y) ^ rotl(y, k);
        return r;
    endfunction

    // final avalanche step: x = (x ^ y) - rotl(y, k)
    function automatic word_t fin_word(input word_t x, input word_t y, input logic [4:0] k);
        word_t r;
        r = (x ^ y) - rotl(y, k);
        return r;
    endfunction

    function automatic abc_t mix_s0(input abc_t v);
        abc_t r;
        r = v;
        r.a = mix_word(r.a, r.c, 5'd4);
        r.c = r.c + r.b;
        r.b = mix_word(r.b, r.a, 5'd6);
        r.a = r.a + r.c;
        return r;
    endfunction

    function automatic abc_t mix_s1(input abc_t v);
        abc_t r;
        r = v;
        r.c = mix_word(r.c, r.b, 5'd8);
        r.b = r.b + r.a;
        r.a = mix_word(r.a, r.c, 5'd16);
        r.c = r.c + r.b;
        return r;
    endfunction

    function automatic abc_t mix_s2(input abc_t v);
        abc_t r;
        r = v;
        r.b = mix_word(r.b, r.a, 5'd19);
        r.a = r.a + r.c;
        r.c = mix_word(r.c, r.b, 5'd4);
        r.b = r.b + r.a;
        return r;
    endfunction

    function automatic abc_t fin_s0(input abc_t v);
        abc_t r;
        r = v;
        r.c = fin_word(r.c, r.b, 5'd14);
        r.a = fin_word(r.a, r.c, 5'd11);
        return r;
    endfunction

    function automatic abc_t fin_s1(input abc_t v);
        abc_t r;
        r = v;
        r.b = fin_word(r.b, r.a, 5'd25);
        r.c = fin_word(r.c, r.b, 5'd16);
        return r;
    endfunction

    function automatic abc_t fin_s2(input abc_t v);
        abc_t r;
        r = v;
        r.a = fin_word(r.a, r.c, 5'd4);
        r.b = fin_word(r.b, r.a, 5'd14);
        return r;
    endfunction

endpackage

// ===== sv/fth_seed.sv =====
// ----------------------------------------------------------------------------
// fth_seed
// Two stages: port product, then seed add into the three hash words.
// ----------------------------------------------------------------------------
module fth_seed
    import fth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_v,
    input  logic [7:0]  protocol,
    input  logic [31:0] src_address,
    input  logic [31:0] dst_address,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    output logic        out_v,
    output abc_t        out_abc
);

    logic        v1_reg;
    logic        v2_reg;
    word_t       prod_reg;
    logic [7:0]  proto_reg;
    word_t       src_reg;
    word_t       dst_reg;
    abc_t        abc_reg;
    word_t       seed;
    abc_t        abc_next;

    always_comb
    begin
        seed       = prod_reg + SEED_INIT;
        abc_next.a = {24'd0, proto_reg} + seed;
        abc_next.b = src_reg + seed;
        abc_next.c = dst_reg + seed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= {16'd0, src_port} * {16'd0, dst_port};
            proto_reg <= protocol;
            src_reg   <= src_address;
            dst_reg   <= dst_address;
            abc_reg   <= abc_next;
        end
    end

    assign out_v   = v2_reg;
    assign out_abc = abc_reg;

endmodule

// ===== sv/fth_mix.sv =====
// ----------------------------------------------------------------------------
// fth_mix
// Full mix round, two steps per stage over three stages.
// ----------------------------------------------------------------------------
module fth_mix
    import fth_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic in_v,
    input  abc_t in_abc,
    output logic out_v,
    output abc_t out_abc
);

    logic [2:0] v_reg;
    abc_t       s0_reg;
    abc_t       s1_reg;
    abc_t       s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[1:0], in_v};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg <= mix_s0(in_abc);
            s1_reg <= mix_s1(s0_reg);
            s2_reg <= mix_s2(s1_reg);
        end
    end

    assign out_v   = v_reg[2];
    assign out_abc = s2_reg;

endmodule

// ===== sv/fth_final.sv =====
// ----------------------------------------------------------------------------
// fth_final
// Final avalanche over four stages; last stage is the output register.
// ----------------------------------------------------------------------------
module fth_final
    import fth_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  in_v,
    input  abc_t  in_abc,
    output logic  out_v,
    output word_t out_c
);

    logic [3:0] v_reg;
    abc_t       s0_reg;
    abc_t       s1_reg;
    abc_t       s2_reg;
    word_t      c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], in_v};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg <= fin_s0(in_abc);
            s1_reg <= fin_s1(s0_reg);
            s2_reg <= fin_s2(s1_reg);
            c_reg  <= fin_word(s2_reg.c, s2_reg.b, 5'd24);
        end
    end

    assign out_v = v_reg[3];
    assign out_c = c_reg;

endmodule

// ===== sv/flow_tuple_hash_core.sv =====
// ----------------------------------------------------------------------------
// flow_tuple_hash_core
// 32-bit flow identifier from five parsed packet header fields.
// ----------------------------------------------------------------------------
// One header transfer is taken per cycle unless frozen, and its flow_hash
// passes two stages for the port product and seed add, three for the mix round
// and four for the final avalanche, the last being the output register. All
// stages advance together; when hash_stall holds a waiting result, the whole
// pipe freezes and hdr_stall rises in the same cycle, so nothing is dropped.
`include "assert_macros.svh"

module flow_tuple_hash_core
    import fth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        hdr_valid,
    output logic        hdr_stall,
    input  logic [7:0]  protocol,
    input  logic [31:0] src_address,
    input  logic [31:0] dst_address,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    output logic        hash_valid,
    input  logic        hash_stall,
    output logic [31:0] flow_hash
);

    logic adv;
    logic seed_v;
    abc_t seed_abc;
    logic mix_v;
    abc_t mix_abc;

    assign adv       = !(hash_valid && hash_stall);
    assign hdr_stall = !adv;

    fth_seed u_seed (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_v        (hdr_valid),
        .protocol    (protocol),
        .src_address (src_address),
        .dst_address (dst_address),
        .src_port    (src_port),
        .dst_port    (dst_port),
        .out_v       (seed_v),
        .out_abc     (seed_abc)
    );

    fth_mix u_mix (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_v    (seed_v),
        .in_abc  (seed_abc),
        .out_v   (mix_v),
        .out_abc (mix_abc)
    );

    fth_final u_final (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .in_v   (mix_v),
        .in_abc (mix_abc),
        .out_v  (hash_valid),
        .out_c  (flow_hash)
    );

    `ASSERT_NEXT(a_frozen_hash_holds, clk, rst_n, hash_valid && hash_stall, hash_valid && $stable(flow_hash))
    `ASSERT_NEXT(a_seed_to_mix, clk, rst_n, adv && seed_v, u_mix.v_reg[0])
    `ASSERT_NEXT(a_mix_to_final, clk, rst_n, adv && mix_v, u_final.v_reg[0])

endmodule

// ===== test/flow_hash_checker.sv =====
// ----------------------------------------------------------------------------
// flow_hash_checker
// Watches both channels of flow_tuple_hash_core, computes the expected flow
// hash for every header transfer and compares it with each hash transfer in
// order. Reports mismatches and keeps count of failures and pending hashes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module flow_hash_checker
    import fth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        hdr_valid,
    input  logic        hdr_stall,
    input  logic [7:0]  protocol,
    input  logic [31:0] src_address,
    input  logic [31:0] dst_address,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic        hash_valid,
    input  logic        hash_stall,
    input  logic [31:0] flow_hash,
    output int          error_count,
    output int          hashes_pending
);

    localparam word_t SEED_START = 32'hdeadbeef + 32'd12;

    word_t hash_expected[$];
    word_t want;
    int    fails = 0;
    int    pend  = 0;

    assign error_count    = fails;
    assign hashes_pending = pend;

    function automatic word_t rol32(input word_t x, input int k);
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic word_t flow_hash_of(input logic [7:0] proto, input word_t saddr,
                                           input word_t daddr, input logic [15:0] sport,
                                           input logic [15:0] dport);
        word_t a;
        word_t b;
        word_t c;
        word_t s;
        s = word_t'(sport) * word_t'(dport) + SEED_START;
        a = word_t'(proto) + s;
        b = saddr + s;
        c = daddr + s;

        a = (a - c) ^ rol32(c, 4);   c = c + b;
        b = (b - a) ^ rol32(a, 6);   a = a + c;
        c = (c - b) ^ rol32(b, 8);   b = b + a;
        a = (a - c) ^ rol32(c, 16);  c = c + b;
        b = (b - a) ^ rol32(a, 19);  a = a + c;
        c = (c - b) ^ rol32(b, 4);   b = b + a;

        c = (c ^ b) - rol32(b, 14);
        a = (a ^ c) - rol32(c, 11);
        b = (b ^ a) - rol32(a, 25);
        c = (c ^ b) - rol32(b, 16);
        a = (a ^ c) - rol32(c, 4);
        b = (b ^ a) - rol32(a, 14);
        c = (c ^ b) - rol32(b, 24);
        return c;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hdr_valid && !hdr_stall)
                hash_expected.push_back(flow_hash_of(protocol, src_address, dst_address,
                                                     src_port, dst_port));
            if (hash_valid && !hash_stall)
            begin
                if (hash_expected.size() == 0)
                begin
                    $error("flow_hash: transfer with none expected, actual %h", flow_hash);
                    fails++;
                end
                else
                begin
                    want = hash_expected.pop_front();
                    if (flow_hash !== want)
                    begin
                        $error("flow_hash: expected %h, actual %h", want, flow_hash);
                        fails++;
                    end
                end
            end
            pend = hash_expected.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives parsed header transfers into flow_tuple_hash_core: a directed set of
// field extremes and bit patterns, then random headers with random sender
// gaps and receiver stalls. A checker beside the core predicts every hash.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import fth_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BLOCKS  = 8;
    localparam int BLOCK_ITEMS    = 200;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        hdr_valid   = 1'b0;
    logic        hdr_stall;
    logic [7:0]  protocol    = '0;
    logic [31:0] src_address = '0;
    logic [31:0] dst_address = '0;
    logic [15:0] src_port    = '0;
    logic [15:0] dst_port    = '0;
    logic        hash_valid;
    logic        hash_stall  = 1'b0;
    logic [31:0] flow_hash;

    logic        idling      = 1'b0;
    int          stall_left  = 0;
    int          quiet_cycles = 0;
    int          error_count;
    int          hashes_pending;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    flow_tuple_hash_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .hdr_valid   (hdr_valid),
        .hdr_stall   (hdr_stall),
        .protocol    (protocol),
        .src_address (src_address),
        .dst_address (dst_address),
        .src_port    (src_port),
        .dst_port    (dst_port),
        .hash_valid  (hash_valid),
        .hash_stall  (hash_stall),
        .flow_hash   (flow_hash)
    );

    flow_hash_checker hash_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .hdr_valid      (hdr_valid),
        .hdr_stall      (hdr_stall),
        .protocol       (protocol),
        .src_address    (src_address),
        .dst_address    (dst_address),
        .src_port       (src_port),
        .dst_port       (dst_port),
        .hash_valid     (hash_valid),
        .hash_stall     (hash_stall),
        .flow_hash      (flow_hash),
        .error_count    (error_count),
        .hashes_pending (hashes_pending)
    );

    // mostly short, now and then long
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(30, 80);
    endfunction

    function automatic word_t pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return $urandom;
    endfunction

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            hash_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            hash_stall <= 1'b0;
            if (idling && $urandom_range(0, 2) == 0)
                stall_left <= pick_len();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((hdr_valid && !hdr_stall) || (hash_valid && !hash_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("flow_tuple_hash_core: mismatch");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_hdr(input logic [7:0] proto, input word_t saddr, input word_t daddr,
                            input logic [15:0] sport, input logic [15:0] dport);
        hdr_valid   <= 1'b1;
        protocol    <= proto;
        src_address <= saddr;
        dst_address <= daddr;
        src_port    <= sport;
        dst_port    <= dport;
        do
            @(posedge clk);
        while (hdr_stall);
    endtask

    task automatic send_random_hdr();
        word_t w0;
        word_t w1;
        word_t w2;
        word_t w3;
        word_t w4;
        w0 = pick_word();
        w1 = pick_word();
        w2 = pick_word();
        w3 = pick_word();
        w4 = pick_word();
        send_hdr(w0[7:0], w1, w2, w3[15:0], w4[15:0]);
    endtask

    task automatic sender_gap();
        if (idling && $urandom_range(0, 1) == 0)
        begin
            hdr_valid <= 1'b0;
            repeat (pick_len()) @(posedge clk);
        end
    endtask

    task automatic drain_hashes();
        hdr_valid <= 1'b0;
        @(posedge clk);
        while (hashes_pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // back to back, receiver never stalls
        send_hdr(8'h00, 32'h00000000, 32'h00000000, 16'h0000, 16'h0000);
        send_hdr(8'hff, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff);
        send_hdr(8'hff, 32'h00000000, 32'h00000000, 16'h0000, 16'h0000);
        send_hdr(8'h00, 32'hffffffff, 32'h00000000, 16'h0000, 16'h0000);
        send_hdr(8'h00, 32'h00000000, 32'hffffffff, 16'h0000, 16'h0000);
        send_hdr(8'h00, 32'h00000000, 32'h00000000, 16'hffff, 16'h0000);
        send_hdr(8'h00, 32'h00000000, 32'h00000000, 16'h0000, 16'hffff);
        send_hdr(8'h00, 32'h00000000, 32'h00000000, 16'hffff, 16'hffff);
        send_hdr(8'haa, 32'haaaaaaaa, 32'h55555555, 16'haaaa, 16'h5555);
        send_hdr(8'h55, 32'h55555555, 32'haaaaaaaa, 16'h5555, 16'haaaa);
        send_hdr(8'd6,  32'hc0a80001, 32'h0a000001, 16'd443, 16'd51234);
        send_hdr(8'd17, 32'h08080808, 32'hc0a8010a, 16'd53, 16'd53);
        send_hdr(8'd1,  32'h00000001, 32'h80000000, 16'd1, 16'd1);
        send_hdr(8'h80, 32'h80000000, 32'h00000001, 16'h8000, 16'h8000);
        send_hdr(8'h01, 32'h7fffffff, 32'hfffffffe, 16'h8000, 16'hffff);
        send_hdr(8'hfe, 32'hfffffffe, 32'h7fffffff, 16'h7fff, 16'h0001);
        drain_hashes();

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            idling <= (blk == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
            for (int n = 0; n < BLOCK_ITEMS; n++)
            begin
                send_random_hdr();
                sender_gap();
            end
            if ($urandom_range(0, 1) == 0)
                drain_hashes();
        end

        drain_hashes();
        repeat (20) @(posedge clk);
        if (error_count == 0 && hashes_pending == 0)
            $display("flow_tuple_hash_core: match");
        else
            $display("flow_tuple_hash_core: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/fth_pkg.sv
sv/fth_seed.sv
sv/fth_mix.sv
sv/fth_final.sv
sv/flow_tuple_hash_core.sv
test/flow_hash_checker.sv
test/testbench.sv
